### rtl/nnu_pkg.sv
// Shared constants and types for the nearest-neighbor upscaler.
// Used by nnu_line_buffer and nearest_neighbor_upscaler; no dependencies.
package nnu_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIXEL_BITS = 32;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);

   localparam int DATA_BITS   = 32;
   localparam int SCALE_BITS  = 3;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 12;
   localparam int REP_BITS    = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = SCALE_BITS'(2);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(768);

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_PULL = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  wr_en;
      logic [COL_BITS-1:0]   wr_addr;
      logic [PIXEL_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [COL_BITS-1:0]   rd_addr;
   } buf_req_type;

endpackage

### rtl/nnu_line_buffer.sv
// One-row line buffer: single write port, single registered read port.
// Depends on nnu_pkg for the request struct and sizes.
module nnu_line_buffer (
   input  logic                           clock,
   input  nnu_pkg::buf_req_type           buf_req,
   output logic [nnu_pkg::PIXEL_BITS-1:0] rd_data
);
   import nnu_pkg::*;

   logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (buf_req.wr_en) begin
         mem[buf_req.wr_addr] <= buf_req.wr_data;
      end
      if (buf_req.rd_en) begin
         rd_data_ff <= mem[buf_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nearest_neighbor_upscaler.sv
// Nearest-neighbor upscaler with a whole-number zoom factor of 1 to 4.
// Depends on nnu_pkg and nnu_line_buffer.
//
// Each request transfer carries an action in req_tuser. A load writes one
// source pixel (req_tdata) into the one-row line buffer, in raster order, and
// returns nothing. A pull returns the next output pixel in raster order on the
// rsp channel, with rsp_tlast on the last pixel of each output row and
// rsp_tuser on the last pixel of the frame. Output columns are tracked with
// replicate counters, so each source pixel is repeated scale times along a row
// and each source row is repeated scale times. The block takes one transfer
// per clock unless a stalled output holds req_tready low; a pull's result
// passes through the registered line-buffer read and then the output register
// before it reaches rsp. Load a source row before pulling its output rows:
// buffer entries hold nothing defined until written, and there is no clearing
// pass after reset. Write the csr registers only while the block is idle;
// out-of-range values are clamped (scale 0 acts as 1, above 4 as 4; width 0
// as 1, above the buffer depth as the depth; height 0 as 1).
module nearest_neighbor_upscaler (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [nnu_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nnu_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nnu_pkg::DATA_BITS-1:0]     req_tdata,  // [31:0] source_pixel
   input  logic                              req_tuser,  // [0] action
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nnu_pkg::DATA_BITS-1:0]     rsp_tdata,  // [31:0] scaled_pixel
   output logic                              rsp_tlast,  // row_end
   output logic                              rsp_tuser   // [0] frame_end
);
   import nnu_pkg::*;

   // ---------------------------------------------------------------- config
   logic [SCALE_BITS-1:0]  scale_ff,  scale_in;
   logic [WIDTH_BITS-1:0]  width_ff,  width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;

   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:  scale_in  = csr_wdata[SCALE_BITS-1:0];
            CSR_WIDTH:  width_in  = csr_wdata[WIDTH_BITS-1:0];
            CSR_HEIGHT: height_in = csr_wdata[HEIGHT_BITS-1:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamped last-index limits: scale-1, width-1, height-1.
   logic [REP_BITS-1:0]    scale_last;
   logic [COL_BITS-1:0]    col_last;
   logic [HEIGHT_BITS-1:0] row_last;

   always_comb begin
      if (scale_ff == '0) begin
         scale_last = '0;
      end else if (32'(scale_ff) > 4) begin
         scale_last = REP_BITS'(3);
      end else begin
         scale_last = REP_BITS'(scale_ff - SCALE_BITS'(1));
      end

      if (width_ff == '0) begin
         col_last = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         col_last = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_BITS'(32'(width_ff) - 1);
      end

      row_last = (height_ff == '0) ? '0 : height_ff - HEIGHT_BITS'(1);
   end

   // ------------------------------------------------------- handshake logic
   logic req_xfer, load_xfer, pull_xfer;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, s1_move;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign load_xfer  = req_xfer && (req_tuser == ACT_LOAD);
   assign pull_xfer  = req_xfer && (req_tuser == ACT_PULL);

   // -------------------------------------------------------------- counters
   logic [COL_BITS-1:0]    load_col_ff, load_col_in;
   logic [COL_BITS-1:0]    src_col_ff,  src_col_in;
   logic [REP_BITS-1:0]    col_rep_ff,  col_rep_in;
   logic [REP_BITS-1:0]    row_rep_ff,  row_rep_in;
   logic [HEIGHT_BITS-1:0] src_row_ff,  src_row_in;
   logic last_copy, last_row_rep, row_end, frame_end;

   // A counter at or past its limit counts as being at its last value.
   assign last_copy    = col_rep_ff >= scale_last;
   assign row_end      = last_copy && (src_col_ff >= col_last);
   assign last_row_rep = row_rep_ff >= scale_last;
   assign frame_end    = row_end && last_row_rep && (src_row_ff >= row_last);

   always_comb begin
      load_col_in = load_col_ff;
      src_col_in  = src_col_ff;
      col_rep_in  = col_rep_ff;
      row_rep_in  = row_rep_ff;
      src_row_in  = src_row_ff;

      if (load_xfer) begin
         // wrap after the last column of a row
         load_col_in = (load_col_ff >= col_last) ? '0 : load_col_ff + COL_BITS'(1);
      end

      if (pull_xfer) begin
         if (row_end) begin
            src_col_in = '0;
            col_rep_in = '0;
            if (last_row_rep) begin
               row_rep_in = '0;
               src_row_in = frame_end ? '0 : src_row_ff + HEIGHT_BITS'(1);
            end else begin
               row_rep_in = row_rep_ff + REP_BITS'(1);
            end
         end else if (last_copy) begin
            col_rep_in = '0;
            src_col_in = src_col_ff + COL_BITS'(1);
         end else begin
            col_rep_in = col_rep_ff + REP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         src_col_ff  <= '0;
         col_rep_ff  <= '0;
         row_rep_ff  <= '0;
         src_row_ff  <= '0;
      end else begin
         load_col_ff <= load_col_in;
         src_col_ff  <= src_col_in;
         col_rep_ff  <= col_rep_in;
         row_rep_ff  <= row_rep_in;
         src_row_ff  <= src_row_in;
      end
   end

   // ----------------------------------------------------------- line buffer
   buf_req_type           buf_req;
   logic [PIXEL_BITS-1:0] buf_rd_data;

   always_comb begin
      buf_req.wr_en   = load_xfer;
      buf_req.wr_addr = load_col_ff;
      buf_req.wr_data = req_tdata[PIXEL_BITS-1:0]; // drop bits above the pixel width
      buf_req.rd_en   = pull_xfer;
      buf_req.rd_addr = src_col_ff;
   end

   nnu_line_buffer u_line_buffer (
      .clock   (clock),
      .buf_req (buf_req),
      .rd_data (buf_rd_data)
   );

   // ------------------------------------------- read stage and output stage
   logic s1_row_end_ff, s1_frame_end_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic rsp_row_end_ff, rsp_frame_end_ff;

   // A pull enters the read stage; a load leaves nothing behind.
   always_comb begin
      if (pull_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Flags travel beside the buffer read; hold them while the stage stalls.
   always_ff @(posedge clock) begin
      if (pull_xfer) begin
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
      if (s1_move) begin
         rsp_data_ff      <= DATA_BITS'(buf_rd_data);
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

   // ------------------------------------------------------------ assertions
   // Only a pull may fill the read stage.
   a_stage_from_pull: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(pull_xfer))
      else $error("read stage filled without a pull transfer");

   // The frame end is always also a row end.
   a_frame_has_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_end_ff) |-> rsp_row_end_ff)
      else $error("frame end without row end");

   // After a row end, replication restarts at column zero.
   a_row_end_restart: assert property (@(posedge clock) disable iff (reset)
      (pull_xfer && row_end) |=> (src_col_ff == '0 && col_rep_ff == '0))
      else $error("column counters did not restart after row end");

   // A new pull never lands on a stage that cannot move.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (pull_xfer && s1_valid_ff) |-> rsp_free)
      else $error("pull accepted over a stalled read stage");

endmodule
